@@ rtl/hrht_pkg.sv @@
package hrht_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CLS_METHOD  = 3'd0,
        CLS_URL     = 3'd1,
        CLS_VERSION = 3'd2,
        CLS_NAME    = 3'd3,
        CLS_VALUE   = 3'd4,
        CLS_DELIM   = 3'd5,
        CLS_BODY    = 3'd6
    } t_class;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_METHOD  = 3'd1,
        ERR_URL     = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_NAME    = 3'd4,
        ERR_VALUE   = 3'd5
    } t_err;

    typedef struct packed {
        t_phase phase;
        logic   cr_pending;
        logic   skip_after_colon;
        logic   at_line_start;
    } t_state;

    typedef struct packed {
        t_class byte_class;
        logic   token_end;
        logic   headers_done;
        t_err   error_code;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:            PH_METHOD,
        cr_pending:       1'b0,
        skip_after_colon: 1'b0,
        at_line_start:    1'b0
    };

endpackage

@@ rtl/hrht_decode.sv @@
module hrht_decode
    import hrht_pkg::*;
(
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_state            o_next_state,
    output t_result           o_result
);

    t_state step_state;

    // next state
    always_comb begin
        step_state = i_state;
        case (i_state.phase)
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    step_state.phase = PH_URL;
                end
            end
            PH_URL: begin
                if (i_byte == CH_SPACE) begin
                    step_state.phase = PH_VERSION;
                end
            end
            PH_NAME: begin
                if (i_state.at_line_start && i_state.cr_pending && i_byte == CH_LF) begin
                    step_state.phase         = PH_BODY;
                    step_state.at_line_start = 1'b0;
                    step_state.cr_pending    = 1'b0;
                end else if (i_state.at_line_start && !i_state.cr_pending
                             && i_byte == CH_CR) begin
                    step_state.cr_pending = 1'b1;
                end else begin
                    step_state.at_line_start = 1'b0;
                    step_state.cr_pending    = 1'b0;
                    if (i_byte == CH_COLON) begin
                        step_state.phase            = PH_VALUE;
                        step_state.skip_after_colon = 1'b1;
                    end
                end
            end
            PH_VERSION, PH_VALUE: begin
                if (i_state.phase == PH_VALUE && i_state.skip_after_colon) begin
                    step_state.skip_after_colon = 1'b0;
                end else if (i_state.cr_pending && i_byte == CH_LF) begin
                    step_state.cr_pending    = 1'b0;
                    step_state.phase         = PH_NAME;
                    step_state.at_line_start = 1'b1;
                end else begin
                    step_state.cr_pending = (i_byte == CH_CR);
                end
            end
            default: begin
            end
        endcase
    end

    // a last byte always restarts the parse
    assign o_next_state = i_last ? STATE_RESET : step_state;

    // outputs
    always_comb begin
        o_result.byte_class   = CLS_BODY;
        o_result.token_end    = 1'b0;
        o_result.headers_done = 1'b0;
        o_result.error_code   = ERR_NONE;
        case (i_state.phase)
            PH_METHOD, PH_URL: begin
                if (i_byte == CH_SPACE) begin
                    o_result.byte_class = CLS_DELIM;
                    o_result.token_end  = 1'b1;
                end else if (i_state.phase == PH_METHOD) begin
                    o_result.byte_class = CLS_METHOD;
                end else begin
                    o_result.byte_class = CLS_URL;
                end
            end
            PH_NAME: begin
                if (i_state.at_line_start && i_state.cr_pending && i_byte == CH_LF) begin
                    o_result.byte_class   = CLS_DELIM;
                    o_result.headers_done = 1'b1;
                end else if (i_byte == CH_COLON
                             && !(i_state.at_line_start && !i_state.cr_pending)) begin
                    o_result.byte_class = CLS_DELIM;
                    o_result.token_end  = 1'b1;
                end else if (i_byte == CH_COLON) begin
                    // at line start with no cr seen yet: colon still closes the name
                    o_result.byte_class = CLS_DELIM;
                    o_result.token_end  = 1'b1;
                end else begin
                    o_result.byte_class = CLS_NAME;
                end
            end
            PH_VERSION, PH_VALUE: begin
                if (i_state.phase == PH_VALUE && i_state.skip_after_colon) begin
                    o_result.byte_class = CLS_DELIM;
                end else if (i_state.cr_pending && i_byte == CH_LF) begin
                    o_result.byte_class = CLS_DELIM;
                    o_result.token_end  = 1'b1;
                end else if (i_state.phase == PH_VERSION) begin
                    o_result.byte_class = CLS_VERSION;
                end else begin
                    o_result.byte_class = CLS_VALUE;
                end
            end
            default: begin
                o_result.byte_class = CLS_BODY;
            end
        endcase

        if (i_last) begin
            case (step_state.phase)
                PH_METHOD:  o_result.error_code = ERR_METHOD;
                PH_URL:     o_result.error_code = ERR_URL;
                PH_VERSION: o_result.error_code = ERR_VERSION;
                PH_NAME:    o_result.error_code = ERR_NAME;
                PH_VALUE:   o_result.error_code = ERR_VALUE;
                default:    o_result.error_code = ERR_NONE;
            endcase
        end
    end

endmodule

@@ rtl/http_request_head_tokenizer.sv @@
// http request head tokenizer
// input channel: i_valid / o_stall with i_data_byte and i_last_byte, one raw
// request byte per request; i_last_byte marks the end of the buffer
// output channel: o_valid / i_stall with one result per byte: the byte, its
// class, token end, headers done and an error code
// a byte taken into the input register is classified by a few byte compares
// against the parse state and moves on into the result register as soon as
// the output side is free; while it is not, the byte waits in the input register
// throughput is one byte per cycle while the output is not stalled; the state
// update loop (phase, cr pending, skip after colon, line start) sets that figure
// a last byte reports the unfinished stage, if any, and returns the parse
// state to the method stage for the next request
// reset empties both registers and puts the parser in the method stage
// while i_stall is high the result holds; the input register still takes one
// more byte, after which o_stall rises until the result moves on
module http_request_head_tokenizer
    import hrht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [2:0]        o_byte_class,
    output logic              o_token_end,
    output logic              o_headers_done,
    output logic [2:0]        o_error_code
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    t_result           r_out_result;
    t_state            r_state;

    t_state            n_state;
    t_result           n_result;

    logic              out_free;
    logic              advance;
    logic              accept;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    hrht_decode u_decode (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_next_state (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (advance) begin
            r_out_byte   <= r_in_byte;
            r_out_last   <= r_in_last;
            r_out_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_class   = r_out_result.byte_class;
    assign o_token_end    = r_out_result.token_end;
    assign o_headers_done = r_out_result.headers_done;
    assign o_error_code   = r_out_result.error_code;

    a_err_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_result.error_code != ERR_NONE |-> r_out_last)
        else $error("error code on a byte that is not last");

    a_done_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_result.headers_done
            |-> r_out_result.byte_class == CLS_DELIM && !r_out_result.token_end)
        else $error("headers done on a byte that is not a plain delimiter");

    a_skip_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_after_colon |-> r_state.phase == PH_VALUE)
        else $error("colon skip outside the value stage");

    a_line_start_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.at_line_start |-> r_state.phase == PH_NAME)
        else $error("line start outside the name stage");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("parse state moved without a byte");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrht_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TARGET_BYTES   = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;
    localparam int DRAIN_AT_REQ   = 12;

    typedef struct {
        logic [BYTE_W-1:0] data;
        t_class            cls;
        logic              tend;
        logic              done;
        t_err              err;
    } t_parse_result;

    // tracks the parse state and holds the results still owed by the block
    class head_parse_tracker;
        t_state        parse_st;
        t_parse_result expected_results[$];
        int            mismatches;

        function new();
            parse_st   = STATE_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic [BYTE_W-1:0] data, logic last);
            t_parse_result r;
            r.data = data;
            r.cls  = CLS_METHOD;
            r.tend = 1'b0;
            r.done = 1'b0;
            r.err  = ERR_NONE;
            case (parse_st.phase)
                PH_METHOD, PH_URL: begin
                    if (data == CH_SPACE) begin
                        r.cls  = CLS_DELIM;
                        r.tend = 1'b1;
                        if (parse_st.phase == PH_METHOD) parse_st.phase = PH_URL;
                        else parse_st.phase = PH_VERSION;
                    end else if (parse_st.phase == PH_METHOD) begin
                        r.cls = CLS_METHOD;
                    end else begin
                        r.cls = CLS_URL;
                    end
                end
                PH_NAME: begin
                    if (parse_st.at_line_start && parse_st.cr_pending && data == CH_LF) begin
                        // blank line closes the head
                        r.cls                  = CLS_DELIM;
                        r.done                 = 1'b1;
                        parse_st.phase         = PH_BODY;
                        parse_st.at_line_start = 1'b0;
                        parse_st.cr_pending    = 1'b0;
                    end else if (parse_st.at_line_start && !parse_st.cr_pending
                                 && data == CH_CR) begin
                        r.cls               = CLS_NAME;
                        parse_st.cr_pending = 1'b1;
                    end else begin
                        parse_st.at_line_start = 1'b0;
                        parse_st.cr_pending    = 1'b0;
                        if (data == CH_COLON) begin
                            r.cls                     = CLS_DELIM;
                            r.tend                    = 1'b1;
                            parse_st.phase            = PH_VALUE;
                            parse_st.skip_after_colon = 1'b1;
                        end else begin
                            r.cls = CLS_NAME;
                        end
                    end
                end
                PH_VERSION, PH_VALUE: begin
                    if (parse_st.phase == PH_VALUE && parse_st.skip_after_colon) begin
                        r.cls                     = CLS_DELIM;
                        parse_st.skip_after_colon = 1'b0;
                    end else if (parse_st.cr_pending && data == CH_LF) begin
                        r.cls                  = CLS_DELIM;
                        r.tend                 = 1'b1;
                        parse_st.cr_pending    = 1'b0;
                        parse_st.phase         = PH_NAME;
                        parse_st.at_line_start = 1'b1;
                    end else begin
                        if (parse_st.phase == PH_VERSION) r.cls = CLS_VERSION;
                        else r.cls = CLS_VALUE;
                        parse_st.cr_pending = (data == CH_CR);
                    end
                end
                default: r.cls = CLS_BODY;
            endcase
            if (last) begin
                case (parse_st.phase)
                    PH_METHOD:  r.err = ERR_METHOD;
                    PH_URL:     r.err = ERR_URL;
                    PH_VERSION: r.err = ERR_VERSION;
                    PH_NAME:    r.err = ERR_NAME;
                    PH_VALUE:   r.err = ERR_VALUE;
                    default:    r.err = ERR_NONE;
                endcase
                parse_st = STATE_RESET;
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] expv, logic [7:0] actv);
            if (actv !== expv) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, expv, actv);
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic [2:0] cls, logic tend,
                                   logic done, logic [2:0] err);
            t_parse_result r;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no request pending, expected none, actual %0h",
                             $time, data);
            end else begin
                r = expected_results.pop_front();
                compare_field("out_byte", r.data, data);
                compare_field("byte_class", 8'(r.cls), 8'(cls));
                compare_field("token_end", 8'(r.tend), 8'(tend));
                compare_field("headers_done", 8'(r.done), 8'(done));
                compare_field("error_code", 8'(r.err), 8'(err));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_last_byte;
    logic              o_valid;
    logic              i_stall;
    logic [BYTE_W-1:0] o_out_byte;
    logic [2:0]        o_byte_class;
    logic              o_token_end;
    logic              o_headers_done;
    logic [2:0]        o_error_code;

    head_parse_tracker tracker;
    bit                send_gaps  = 1'b1;
    bit                out_stalls = 1'b1;
    int                stall_left = 0;
    int                idle_cycles = 0;
    logic [BYTE_W-1:0] req_bytes[$];

    http_request_head_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_class   (o_byte_class),
        .o_token_end    (o_token_end),
        .o_headers_done (o_headers_done),
        .o_error_code   (o_error_code)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // mostly printable, sometimes any byte value, never one of the delimiters
    function automatic logic [BYTE_W-1:0] token_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 99) < 85) b = 8'($urandom_range(8'h21, 8'h7E));
        else b = 8'($urandom_range(0, 255));
        if (b == CH_SPACE || b == CH_COLON || b == CH_CR || b == CH_LF) b = b ^ 8'h40;
        return b;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(b, last);
        if (send_gaps && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            repeat (gap_length()) @(posedge i_clk);
        end
    endtask

    task automatic send_seq(input string s, input logic last);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], last && (k == s.len() - 1));
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // lone carriage returns are mixed into the token now and then
    task automatic add_token(input int len);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) req_bytes.push_back(CH_CR);
            req_bytes.push_back(token_byte());
        end
    endtask

    task automatic build_request();
        int nhdr;
        int cut;
        req_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            // noise: delimiters and raw bytes in any order
            repeat ($urandom_range(1, 20)) begin
                case ($urandom_range(0, 7))
                    0: req_bytes.push_back(CH_SPACE);
                    1: req_bytes.push_back(CH_CR);
                    2: req_bytes.push_back(CH_LF);
                    3: req_bytes.push_back(CH_COLON);
                    default: req_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            add_token($urandom_range(1, 6));
            req_bytes.push_back(CH_SPACE);
            add_token($urandom_range(1, 10));
            req_bytes.push_back(CH_SPACE);
            add_token($urandom_range(1, 8));
            req_bytes.push_back(CH_CR);
            req_bytes.push_back(CH_LF);
            nhdr = $urandom_range(0, 3);
            repeat (nhdr) begin
                add_token($urandom_range(1, 6));
                req_bytes.push_back(CH_COLON);
                req_bytes.push_back(8'($urandom_range(0, 255)));
                add_token($urandom_range(0, 6));
                req_bytes.push_back(CH_CR);
                req_bytes.push_back(CH_LF);
            end
            req_bytes.push_back(CH_CR);
            req_bytes.push_back(CH_LF);
            repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
            // truncated requests can end in any phase
            if ($urandom_range(0, 99) < 25) begin
                cut = $urandom_range(1, req_bytes.size());
                while (req_bytes.size() > cut) void'(req_bytes.pop_back());
            end
        end
    endtask

    // output side: check results, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall)
                tracker.check_result(o_out_byte, o_byte_class, o_token_end,
                                     o_headers_done, o_error_code);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (out_stalls && $urandom_range(0, 99) < 25) begin
                i_stall    <= 1'b1;
                stall_left = gap_length() - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL http_request_head_tokenizer");
            $finish;
        end
    end

    initial begin
        int sent_bytes;
        int req_no;
        tracker     = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero byte as last: method unfinished
        send_byte(8'h00, 1'b1);
        // last on the space after the method: url unfinished
        send_seq("\377 ", 1'b1);
        // lone cr in version, blank line right after the request line, body byte
        send_seq("  V\015\015\012\015\012\377", 1'b1);
        // skipped colon, lone cr in value, cr at line start not followed by lf
        send_seq("  \015\012N::\015x\015\012\015Q", 1'b1);

        sent_bytes = 0;
        req_no     = 0;
        while (sent_bytes < TARGET_BYTES) begin
            build_request();
            send_gaps  = ($urandom_range(0, 3) != 0);
            out_stalls = ($urandom_range(0, 3) != 0);
            foreach (req_bytes[k])
                send_byte(req_bytes[k],
                          (k == req_bytes.size() - 1) && ($urandom_range(0, 9) != 0));
            sent_bytes += req_bytes.size();
            req_no++;
            if (req_no == DRAIN_AT_REQ) begin
                i_valid <= 1'b0;
                wait_drained();
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("PASS http_request_head_tokenizer");
        end else begin
            $display("FAIL http_request_head_tokenizer");
        end
        $finish;
    end
endmodule

@@ http_request_head_tokenizer.f @@
rtl/hrht_pkg.sv
rtl/hrht_decode.sv
rtl/http_request_head_tokenizer.sv
bench/tb_top.sv
